@@ design/fstsr_pkg.sv @@
// Shared types, constants and helpers for the flat-shaded triangle span rasterizer.
// No dependencies; every design file imports this package.
`timescale 1ns / 1ps

package fstsr_pkg;

  localparam int SCREEN_WIDTH  = 640;
  localparam int SCREEN_HEIGHT = 640;

  localparam int VW         = 16;          // vertex / normal / light component width
  localparam int COLOR_W    = 24;
  localparam int OUT_W      = 10;          // span row / column field width
  localparam int CW         = 14;          // screen coordinate width, signed
  localparam int XW         = 16;          // span edge x width, signed
  localparam int SLOPE_W    = 32;          // Q16.16 edge slope
  localparam int FRAC_W     = 16;
  localparam int PROJ_SHIFT = 14;
  localparam int DEN_W      = CW - 1;      // |dy| magnitude
  localparam int NUM_W      = DEN_W + FRAC_W;
  localparam int PW         = SLOPE_W + CW + 1;
  localparam int DOT_W      = 2 * VW + 1;

  localparam logic signed [VW-1:0] LIGHT_RESET = 16'sd18265;
  localparam logic signed [CW-1:0] ROW_MAX = CW'(SCREEN_HEIGHT - 1);
  localparam logic signed [XW-1:0] COL_MAX = XW'(SCREEN_WIDTH - 1);

  typedef enum logic [1:0] {
    CFG_LIGHT_X = 2'd0,
    CFG_LIGHT_Y = 2'd1,
    CFG_LIGHT_Z = 2'd2
  } cfg_idx_e;

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_TOP,
    PH_BOT
  } phase_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_PROJ,
    ST_DOT,
    ST_SUM,
    ST_SHADE,
    ST_DIV_START,
    ST_DIV_WAIT,
    ST_SETUP,
    ST_TK_MUL,
    ST_TK_OUT
  } back_state_e;

  typedef struct packed {
    logic                       is_tick;
    logic signed [VW-1:0]       v0_x;
    logic signed [VW-1:0]       v0_y;
    logic signed [VW-1:0]       v1_x;
    logic signed [VW-1:0]       v1_y;
    logic signed [VW-1:0]       v2_x;
    logic signed [VW-1:0]       v2_y;
    logic signed [VW-1:0]       normal_x;
    logic signed [VW-1:0]       normal_y;
    logic signed [VW-1:0]       normal_z;
    logic        [COLOR_W-1:0]  base_color;
  } item_t;

  typedef struct packed {
    logic             start;
    logic [NUM_W-1:0] num;
    logic [DEN_W-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [NUM_W-1:0] quo;
  } div_rsp_t;

  // trunc((v + 0.5) * size) with v in Q2.14, rounding toward zero
  function automatic logic signed [CW-1:0] proj(input logic signed [VW-1:0] v,
                                                input int size);
    logic signed [VW:0]      vb;
    logic signed [VW+CW:0]   n;
    logic        [VW+CW:0]   mag;
    logic        [VW+CW:0]   q;
    vb  = $signed({v[VW-1], v}) + $signed((VW+1)'(8192));
    n   = (VW+CW+1)'(vb * (VW+CW+1)'(size));
    mag = n[VW+CW] ? (VW+CW+1)'(-n) : n;
    q   = mag >> PROJ_SHIFT;
    proj = n[VW+CW] ? CW'(-q) : CW'(q);
  endfunction

endpackage

@@ design/fstsr_front.sv @@
// Input side: unpacks stream transfers into items and buffers them in a 2-deep queue.
// Depends on fstsr_pkg.
`timescale 1ns / 1ps

module fstsr_front import fstsr_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [167:0] s_axis_tdata,
  input  logic         s_axis_tuser,
  output item_t        item_o,
  output logic         item_valid_o,
  input  logic         item_pop_i
);

  item_t       mem_q [2];
  logic        wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [1:0]  cnt_q, cnt_d;
  logic        push;
  item_t       in_item;

  always_comb begin
    in_item.is_tick    = s_axis_tuser;
    in_item.v0_x       = s_axis_tdata[15:0];
    in_item.v0_y       = s_axis_tdata[31:16];
    in_item.v1_x       = s_axis_tdata[47:32];
    in_item.v1_y       = s_axis_tdata[63:48];
    in_item.v2_x       = s_axis_tdata[79:64];
    in_item.v2_y       = s_axis_tdata[95:80];
    in_item.normal_x   = s_axis_tdata[111:96];
    in_item.normal_y   = s_axis_tdata[127:112];
    in_item.normal_z   = s_axis_tdata[143:128];
    in_item.base_color = s_axis_tdata[167:144];
  end

  assign s_axis_tready = (cnt_q != 2'd2);
  assign push          = s_axis_tvalid && s_axis_tready;
  assign item_valid_o  = (cnt_q != 2'd0);
  assign item_o        = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = item_pop_i ? ~rd_ptr_q : rd_ptr_q;
    cnt_d    = cnt_q + 2'(push) - 2'(item_pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= in_item;
    end
  end

endmodule

@@ design/fstsr_div.sv @@
// Restoring divider, one quotient bit per cycle, unsigned operands.
// Depends on fstsr_pkg.
`timescale 1ns / 1ps

module fstsr_div import fstsr_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  div_req_t req_i,
  output div_rsp_t rsp_o
);

  localparam int CNT_W = $clog2(NUM_W + 1);

  logic [NUM_W-1:0] quo_q, quo_d;
  logic [DEN_W:0]   rem_q, rem_d;
  logic [DEN_W-1:0] den_q, den_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             done_q, done_d;
  logic [DEN_W:0]   rem_sh;

  always_comb begin
    quo_d  = quo_q;
    rem_d  = rem_q;
    den_d  = den_q;
    cnt_d  = cnt_q;
    done_d = 1'b0;
    rem_sh = {rem_q[DEN_W-1:0], quo_q[NUM_W-1]};
    if (req_i.start) begin
      quo_d = req_i.num;
      rem_d = '0;
      den_d = req_i.den;
      cnt_d = CNT_W'(NUM_W);
    end else if (cnt_q != '0) begin
      if (rem_sh >= {1'b0, den_q}) begin
        rem_d = rem_sh - {1'b0, den_q};
        quo_d = {quo_q[NUM_W-2:0], 1'b1};
      end else begin
        rem_d = rem_sh;
        quo_d = {quo_q[NUM_W-2:0], 1'b0};
      end
      cnt_d  = cnt_q - CNT_W'(1);
      done_d = (cnt_q == CNT_W'(1));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    den_q <= den_d;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quo  = quo_q;

endmodule

@@ design/fstsr_back.sv @@
// Execution side: triangle setup (projection, sort, shading, slopes) and span walker.
// Depends on fstsr_pkg; drives the shared divider fstsr_div.
`timescale 1ns / 1ps

module fstsr_back import fstsr_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [1:0]         cfg_addr_i,
  input  logic [VW-1:0]      cfg_wdata_i,
  input  item_t              item_i,
  input  logic               item_valid_i,
  output logic               item_pop_o,
  output div_req_t           div_req_o,
  input  div_rsp_t           div_rsp_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [OUT_W-1:0]   row_o,
  output logic [OUT_W-1:0]   start_o,
  output logic [OUT_W-1:0]   end_o,
  output logic [COLOR_W-1:0] color_o,
  output logic               last_o
);

  back_state_e state_q, state_d;
  phase_e      phase_q, phase_n;

  logic signed [VW-1:0]      light_q [3];
  item_t                     cur_q;
  logic signed [CW-1:0]      px_q [3];
  logic signed [CW-1:0]      py_q [3];
  logic signed [2*VW-1:0]    prod_q [3];
  logic        [DOT_W-2:0]   dpos_q;
  logic        [COLOR_W-1:0] color_q;
  logic signed [SLOPE_W-1:0] slope_q [4];
  logic        [1:0]         k_q;
  logic                      top_flat_q, bot_flat_q, bot_ok_q;
  logic signed [CW-1:0]      top_last_q, bot_first_q, bot_last_q, row_q, row_n;
  logic signed [PW-1:0]      mul_a_q, mul_b_q;

  logic                      out_valid_q;
  logic        [OUT_W-1:0]   out_row_q, out_start_q, out_end_q;
  logic        [COLOR_W-1:0] out_color_q;
  logic                      out_last_q;
  logic                      out_wr;

  // projection and stable three-compare sort by row
  logic signed [CW-1:0] ax [3];
  logic signed [CW-1:0] ay [3];
  logic signed [CW-1:0] tx, ty;

  always_comb begin
    tx    = '0;
    ty    = '0;
    ax[0] = proj(cur_q.v0_x, SCREEN_WIDTH);
    ay[0] = proj(cur_q.v0_y, SCREEN_HEIGHT);
    ax[1] = proj(cur_q.v1_x, SCREEN_WIDTH);
    ay[1] = proj(cur_q.v1_y, SCREEN_HEIGHT);
    ax[2] = proj(cur_q.v2_x, SCREEN_WIDTH);
    ay[2] = proj(cur_q.v2_y, SCREEN_HEIGHT);
    if (ay[1] < ay[0]) begin
      tx = ax[0]; ty = ay[0]; ax[0] = ax[1]; ay[0] = ay[1]; ax[1] = tx; ay[1] = ty;
    end
    if (ay[2] < ay[1]) begin
      tx = ax[1]; ty = ay[1]; ax[1] = ax[2]; ay[1] = ay[2]; ax[2] = tx; ay[2] = ty;
    end
    if (ay[1] < ay[0]) begin
      tx = ax[0]; ty = ay[0]; ax[0] = ax[1]; ay[0] = ay[1]; ax[1] = tx; ay[1] = ty;
    end
  end

  // shading
  logic signed [DOT_W-1:0]  dot_sum;
  logic        [COLOR_W-1:0] shade;
  logic        [39:0]       chp [3];

  always_comb begin
    dot_sum = DOT_W'(prod_q[0]) + DOT_W'(prod_q[1]) + DOT_W'(prod_q[2]);
    for (int i = 0; i < 3; i++) begin
      chp[i] = 40'(cur_q.base_color[8*i +: 8]) * 40'(dpos_q);
      shade[8*i +: 8] = (chp[i][39:30] > 10'd255) ? 8'hFF : chp[i][37:30];
    end
  end

  // slope operands for edge k
  logic signed [CW:0] dx, dy, dxm, dym;

  always_comb begin
    case (k_q)
      2'd0: begin
        dx = (CW+1)'(px_q[1]) - (CW+1)'(px_q[0]);
        dy = (CW+1)'(py_q[1]) - (CW+1)'(py_q[0]);
      end
      2'd1: begin
        dx = (CW+1)'(px_q[2]) - (CW+1)'(px_q[0]);
        dy = (CW+1)'(py_q[2]) - (CW+1)'(py_q[0]);
      end
      2'd2: begin
        dx = (CW+1)'(px_q[0]) - (CW+1)'(px_q[2]);
        dy = (CW+1)'(py_q[0]) - (CW+1)'(py_q[2]);
      end
      default: begin
        dx = (CW+1)'(px_q[1]) - (CW+1)'(px_q[2]);
        dy = (CW+1)'(py_q[1]) - (CW+1)'(py_q[2]);
      end
    endcase
    dxm = dx[CW] ? -dx : dx;
    dym = dy[CW] ? -dy : dy;
  end

  logic signed [SLOPE_W-1:0] slope_res;
  logic        [SLOPE_W-1:0] quo_ext;

  always_comb begin
    quo_ext = SLOPE_W'(div_rsp_i.quo);
    if (dy == '0) begin
      slope_res = '0;
    end else if (dx[CW] ^ dy[CW]) begin
      slope_res = -$signed(quo_ext);
    end else begin
      slope_res = $signed(quo_ext);
    end
  end

  assign div_req_o.start = (state_q == ST_DIV_START);
  assign div_req_o.num   = {dxm[DEN_W-1:0], {FRAC_W{1'b0}}};
  assign div_req_o.den   = dym[DEN_W-1:0];

  // half setup
  logic                 s_top_flat, s_bot_flat, s_top_ok, s_bot_ok;
  logic signed [CW-1:0] tf_first, tf_last, b_first, b_last;
  logic signed [CW-1:0] s_top_first, s_top_last, s_bot_first, s_bot_last;

  always_comb begin
    s_top_flat = (py_q[0] == py_q[1]);
    s_bot_flat = (py_q[0] == py_q[2]);
    tf_first   = (py_q[0] < 0) ? '0 : py_q[0];
    tf_last    = (py_q[1] > ROW_MAX) ? ROW_MAX : py_q[1];
    b_first    = (py_q[2] > ROW_MAX) ? ROW_MAX : py_q[2];
    b_last     = ((py_q[1] < 0) ? '0 : py_q[1]) + CW'(1);
    if (s_top_flat) begin
      s_top_ok    = (py_q[0] > 0) && (py_q[0] < ROW_MAX);
      s_top_first = py_q[0];
      s_top_last  = py_q[0];
    end else begin
      s_top_ok    = (tf_first <= tf_last);
      s_top_first = tf_first;
      s_top_last  = tf_last;
    end
    if (s_bot_flat) begin
      s_bot_ok    = (py_q[0] > 0) && (py_q[0] < ROW_MAX);
      s_bot_first = py_q[0];
      s_bot_last  = py_q[0];
    end else begin
      s_bot_ok    = (b_first >= b_last);
      s_bot_first = b_first;
      s_bot_last  = b_last;
    end
  end

  // span walker
  logic signed [CW:0]        yp;
  logic signed [SLOPE_W-1:0] sa, sb;
  logic signed [XW-1:0]      off_a, off_b, xa, xb, lo, hi, lm1, hp1, sp_s, sp_e;

  function automatic logic signed [XW-1:0] off_trunc(input logic signed [PW-1:0] p);
    logic [PW-1:0] mag;
    logic [PW-1:0] q;
    mag = p[PW-1] ? PW'(-p) : p;
    q   = mag >> FRAC_W;
    off_trunc = p[PW-1] ? XW'(-q) : XW'(q);
  endfunction

  always_comb begin
    if (phase_q == PH_TOP) begin
      yp = (CW+1)'(row_q) - (CW+1)'(py_q[0]);
      sa = slope_q[0];
      sb = slope_q[1];
    end else begin
      yp = (CW+1)'(py_q[2]) - (CW+1)'(row_q);
      sa = slope_q[2];
      sb = slope_q[3];
    end
    off_a = off_trunc(mul_a_q);
    off_b = off_trunc(mul_b_q);
    if (phase_q == PH_TOP) begin
      if (top_flat_q) begin
        xa = XW'(px_q[0]);
        xb = XW'(px_q[1]);
      end else begin
        xa = XW'(px_q[0]) + off_a;
        xb = XW'(px_q[0]) + off_b;
      end
    end else begin
      if (bot_flat_q) begin
        xa = XW'(px_q[0]);
        xb = XW'(px_q[2]);
      end else begin
        xa = XW'(px_q[2]) - off_a;
        xb = XW'(px_q[2]) - off_b;
      end
    end
    lo   = (xa < xb) ? xa : xb;
    hi   = (xa > xb) ? xa : xb;
    lm1  = lo - XW'(1);
    hp1  = hi + XW'(1);
    sp_s = (lm1 < 0) ? '0 : ((lm1 > COL_MAX) ? COL_MAX : lm1);
    sp_e = (hp1 > COL_MAX) ? COL_MAX : ((hp1 < 0) ? '0 : hp1);

    phase_n = phase_q;
    row_n   = row_q;
    if (phase_q == PH_TOP) begin
      if (top_flat_q || row_q >= top_last_q) begin
        if (bot_ok_q) begin
          phase_n = PH_BOT;
          row_n   = bot_first_q;
        end else begin
          phase_n = PH_IDLE;
          row_n   = '0;
        end
      end else begin
        row_n = row_q + CW'(1);
      end
    end else begin
      if (bot_flat_q || row_q <= bot_last_q) begin
        phase_n = PH_IDLE;
        row_n   = '0;
      end else begin
        row_n = row_q - CW'(1);
      end
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (item_valid_i) begin
          if (!item_i.is_tick) begin
            state_d = ST_PROJ;
          end else if (phase_q != PH_IDLE) begin
            state_d = ST_TK_MUL;
          end
        end
      end
      ST_PROJ:      state_d = ST_DOT;
      ST_DOT:       state_d = ST_SUM;
      ST_SUM:       state_d = ST_SHADE;
      ST_SHADE:     state_d = ST_DIV_START;
      ST_DIV_START: state_d = ST_DIV_WAIT;
      ST_DIV_WAIT: begin
        if (div_rsp_i.done) begin
          state_d = (k_q == 2'd3) ? ST_SETUP : ST_DIV_START;
        end
      end
      ST_SETUP:     state_d = ST_IDLE;
      ST_TK_MUL:    state_d = ST_TK_OUT;
      ST_TK_OUT: begin
        if (out_wr) begin
          state_d = ST_IDLE;
        end
      end
      default:      state_d = ST_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    item_pop_o = 1'b0;
    out_wr     = 1'b0;
    case (state_q)
      ST_IDLE:   item_pop_o = item_valid_i;
      ST_TK_OUT: out_wr     = !out_valid_q || out_ready_i;
      default: begin
        item_pop_o = 1'b0;
        out_wr     = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      phase_q     <= PH_IDLE;
      row_q       <= '0;
      k_q         <= '0;
      out_valid_q <= 1'b0;
      light_q[0]  <= LIGHT_RESET;
      light_q[1]  <= LIGHT_RESET;
      light_q[2]  <= LIGHT_RESET;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        if (cfg_addr_i == CFG_LIGHT_X) light_q[0] <= cfg_wdata_i;
        if (cfg_addr_i == CFG_LIGHT_Y) light_q[1] <= cfg_wdata_i;
        if (cfg_addr_i == CFG_LIGHT_Z) light_q[2] <= cfg_wdata_i;
      end
      if (state_q == ST_SHADE) begin
        k_q <= '0;
      end else if (state_q == ST_DIV_WAIT && div_rsp_i.done) begin
        k_q <= k_q + 2'd1;
      end
      if (state_q == ST_SETUP) begin
        if (s_top_ok) begin
          phase_q <= PH_TOP;
          row_q   <= s_top_first;
        end else if (s_bot_ok) begin
          phase_q <= PH_BOT;
          row_q   <= s_bot_first;
        end else begin
          phase_q <= PH_IDLE;
          row_q   <= '0;
        end
      end else if (out_wr) begin
        phase_q <= phase_n;
        row_q   <= row_n;
      end
      if (out_wr) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (item_pop_o) begin
      cur_q <= item_i;
    end
    if (state_q == ST_PROJ) begin
      for (int i = 0; i < 3; i++) begin
        px_q[i] <= ax[i];
        py_q[i] <= ay[i];
      end
    end
    if (state_q == ST_DOT) begin
      prod_q[0] <= (2*VW)'(light_q[0]) * (2*VW)'(cur_q.normal_x);
      prod_q[1] <= (2*VW)'(light_q[1]) * (2*VW)'(cur_q.normal_y);
      prod_q[2] <= (2*VW)'(light_q[2]) * (2*VW)'(cur_q.normal_z);
    end
    if (state_q == ST_SUM) begin
      dpos_q <= dot_sum[DOT_W-1] ? '0 : dot_sum[DOT_W-2:0];
    end
    if (state_q == ST_SHADE) begin
      color_q <= shade;
    end
    if (state_q == ST_DIV_WAIT && div_rsp_i.done) begin
      slope_q[k_q] <= slope_res;
    end
    if (state_q == ST_SETUP) begin
      top_flat_q  <= s_top_flat;
      bot_flat_q  <= s_bot_flat;
      bot_ok_q    <= s_bot_ok;
      top_last_q  <= s_top_last;
      bot_first_q <= s_bot_first;
      bot_last_q  <= s_bot_last;
    end
    if (state_q == ST_TK_MUL) begin
      mul_a_q <= PW'(sa) * PW'(yp);
      mul_b_q <= PW'(sb) * PW'(yp);
    end
    if (out_wr) begin
      out_row_q   <= row_q[OUT_W-1:0];
      out_start_q <= sp_s[OUT_W-1:0];
      out_end_q   <= sp_e[OUT_W-1:0];
      out_color_q <= color_q;
      out_last_q  <= (phase_n == PH_IDLE);
    end
  end

  assign out_valid_o = out_valid_q;
  assign row_o       = out_row_q;
  assign start_o     = out_start_q;
  assign end_o       = out_end_q;
  assign color_o     = out_color_q;
  assign last_o      = out_last_q;

endmodule

@@ design/flat_shaded_triangle_span_rasterizer.sv @@
// Top level of the flat-shaded triangle span rasterizer.
// Depends on fstsr_pkg, fstsr_front, fstsr_div and fstsr_back.
`timescale 1ns / 1ps

// A load transfer (tuser 0) brings one triangle; the block projects, sorts and
// shades it and computes four Q16.16 edge slopes on one shared bit-serial divider,
// so a load occupies the back end until its setup is done
// and never produces output. Each tick transfer (tuser 1) then yields one span
// (slope multiply, then span clamp into the output register, which waits while that
// register is full and not taken); a tick while no triangle is active is dropped. A two-entry input queue lets
// the source keep sending while setup runs, and the output register holds a span
// until it is taken. Light direction registers may be written only while idle.
module flat_shaded_triangle_span_rasterizer import fstsr_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         cfg_we_i,
  input  logic [1:0]   cfg_addr_i,
  input  logic [15:0]  cfg_wdata_i,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // v0_x, v0_y, v1_x, v1_y, v2_x, v2_y, normal_x, normal_y, normal_z, base_color
  input  logic [167:0] s_axis_tdata,
  // req_type
  input  logic         s_axis_tuser,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // span_row, span_start, span_end, span_color, two zero bits
  output logic [55:0]  m_axis_tdata,
  // last_span
  output logic         m_axis_tlast
);

  item_t                item;
  logic                 item_valid, item_pop;
  div_req_t             div_req;
  div_rsp_t             div_rsp;
  logic [OUT_W-1:0]     row, start, span_end;
  logic [COLOR_W-1:0]   color;

  fstsr_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .item_o        (item),
    .item_valid_o  (item_valid),
    .item_pop_i    (item_pop)
  );

  fstsr_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  fstsr_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_addr_i   (cfg_addr_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .item_i       (item),
    .item_valid_i (item_valid),
    .item_pop_o   (item_pop),
    .div_req_o    (div_req),
    .div_rsp_i    (div_rsp),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .row_o        (row),
    .start_o      (start),
    .end_o        (span_end),
    .color_o      (color),
    .last_o       (m_axis_tlast)
  );

  assign m_axis_tdata = {2'b00, color, span_end, start, row};

endmodule

@@ design/fstsr_checker.sv @@
// Port-level checks for the span output of the rasterizer, bound to the top level.
// Depends on fstsr_pkg.
`timescale 1ns / 1ps

module fstsr_checker import fstsr_pkg::*; (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [55:0] m_axis_tdata
);

  localparam logic [OUT_W-1:0] LAST_COL = OUT_W'(SCREEN_WIDTH - 1);
  localparam logic [OUT_W-1:0] LAST_ROW = OUT_W'(SCREEN_HEIGHT - 1);

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("span transfer dropped while stalled");

  // valid is cleared by the asynchronous reset itself, so it is sampled once reset has been seen low
  a_reset_quiet: assert property (@(posedge clk_i)
    !rst_ni |=> !m_axis_tvalid)
    else $error("span valid during reset");

  a_cols: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[19:10] <= LAST_COL && m_axis_tdata[29:20] <= LAST_COL)
    else $error("span column off screen");

  a_row: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[9:0] <= LAST_ROW)
    else $error("span row off screen");

endmodule

bind flat_shaded_triangle_span_rasterizer fstsr_checker u_fstsr_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

@@ dv/flat_shaded_triangle_span_rasterizer_test.sv @@
// Self-checking testbench for flat_shaded_triangle_span_rasterizer: random and directed
// triangle loads and span ticks, predicted spans compared per field. Needs fstsr_pkg.
`timescale 1ns / 1ps

module flat_shaded_triangle_span_rasterizer_test;
  import fstsr_pkg::*;

  localparam int ITEM_W = $bits(item_t);

  typedef struct {
    logic [9:0]  row;
    logic [9:0]  col_lo;
    logic [9:0]  col_hi;
    logic [23:0] color;
    logic        last;
  } span_t;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         cfg_we_i = 1'b0;
  logic [1:0]   cfg_addr_i = '0;
  logic [15:0]  cfg_wdata_i = '0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [167:0] s_axis_tdata = '0;
  logic         s_axis_tuser = 1'b0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [55:0]  m_axis_tdata;
  logic         m_axis_tlast;

  flat_shaded_triangle_span_rasterizer u_dut (.*);

  always #1 clk_i = ~clk_i;

  // shading / walking state mirrored from the block
  logic signed [15:0] light_x = LIGHT_RESET, light_y = LIGHT_RESET, light_z = LIGHT_RESET;
  longint  pt[6];
  longint  slp[4];
  logic [23:0] flat_color;
  phase_e  walk = PH_IDLE;
  longint  row_now, top_end, bot_start, bot_end;
  bit      top_flat, bot_flat, bot_live;

  item_t   pending_items[$];
  span_t   spans_due[$];
  int      errors = 0, n_loads = 0, n_ticks = 0, n_spans = 0;
  longint  cycles = 0;
  bit      in_acc = 0, out_acc = 0, quiet = 0;
  int      send_gap = 0, recv_stall = 0, long_hold = 0;

  function automatic longint div0(longint n, longint d);
    if (d <= 0) return 0;
    return n / d;  // truncates toward zero
  endfunction

  function automatic longint to_screen(logic signed [15:0] v);
    return div0((longint'(v) + 8192) * 640, 16384);
  endfunction

  function automatic longint edge_slope(longint dx, longint dy);
    longint n;
    n = dx * 65536;
    if (dy == 0) return 0;
    if (dy < 0) begin
      n = -n;
      dy = -dy;
    end
    return longint'(int'(div0(n, dy)));
  endfunction

  function automatic logic [7:0] lit(logic [7:0] ch, longint d);
    longint v;
    v = (longint'(ch) * d) >>> 30;
    return (v > 255) ? 8'hff : v[7:0];
  endfunction

  function automatic void swap_vtx(int a, int b);
    longint tx, ty;
    tx = pt[2*a]; ty = pt[2*a+1];
    pt[2*a] = pt[2*b]; pt[2*a+1] = pt[2*b+1];
    pt[2*b] = tx; pt[2*b+1] = ty;
  endfunction

  function automatic void load_triangle(item_t it);
    longint d, top_start;
    bit top_live;
    pt[0] = to_screen(it.v0_x); pt[1] = to_screen(it.v0_y);
    pt[2] = to_screen(it.v1_x); pt[3] = to_screen(it.v1_y);
    pt[4] = to_screen(it.v2_x); pt[5] = to_screen(it.v2_y);
    if (pt[3] < pt[1]) swap_vtx(0, 1);
    if (pt[5] < pt[3]) swap_vtx(1, 2);
    if (pt[3] < pt[1]) swap_vtx(0, 1);
    d = longint'(light_x) * it.normal_x + longint'(light_y) * it.normal_y
      + longint'(light_z) * it.normal_z;
    if (d < 0) d = 0;
    flat_color = {lit(it.base_color[23:16], d), lit(it.base_color[15:8], d),
                  lit(it.base_color[7:0], d)};
    top_flat = (pt[1] == pt[3]);
    if (top_flat) begin
      top_live = pt[1] > 0 && pt[1] < SCREEN_HEIGHT - 1;
      top_start = pt[1]; top_end = pt[1];
      slp[0] = 0; slp[1] = 0;
    end else begin
      top_start = (pt[1] > 0) ? pt[1] : 0;
      top_end = (pt[3] < SCREEN_HEIGHT - 1) ? pt[3] : SCREEN_HEIGHT - 1;
      top_live = top_start <= top_end;
      slp[0] = edge_slope(pt[2] - pt[0], pt[3] - pt[1]);
      slp[1] = edge_slope(pt[4] - pt[0], pt[5] - pt[1]);
    end
    bot_flat = (pt[1] == pt[5]);
    if (bot_flat) begin
      bot_live = pt[1] > 0 && pt[1] < SCREEN_HEIGHT - 1;
      bot_start = pt[1]; bot_end = pt[1];
      slp[2] = 0; slp[3] = 0;
    end else begin
      bot_start = (pt[5] < SCREEN_HEIGHT - 1) ? pt[5] : SCREEN_HEIGHT - 1;
      bot_end = ((pt[3] > 0) ? pt[3] : 0) + 1;
      bot_live = bot_start >= bot_end;
      slp[2] = edge_slope(pt[0] - pt[4], pt[1] - pt[5]);
      slp[3] = edge_slope(pt[2] - pt[4], pt[3] - pt[5]);
    end
    if (top_live) begin
      walk = PH_TOP; row_now = top_start;
    end else if (bot_live) begin
      walk = PH_BOT; row_now = bot_start;
    end else begin
      walk = PH_IDLE; row_now = 0;
    end
  endfunction

  function automatic void next_span();
    longint xa, xb, lo, hi, s, e, r;
    span_t sp;
    r = row_now;
    if (walk == PH_TOP) begin
      if (top_flat) begin
        xa = pt[0]; xb = pt[2];
      end else begin
        xa = pt[0] + div0(slp[0] * (r - pt[1]), 1) / 65536;
        xb = pt[0] + div0(slp[1] * (r - pt[1]), 1) / 65536;
      end
      if (top_flat || r >= top_end) begin
        if (bot_live) begin
          walk = PH_BOT; row_now = bot_start;
        end else walk = PH_IDLE;
      end else row_now = r + 1;
    end else begin
      if (bot_flat) begin
        xa = pt[0]; xb = pt[4];
      end else begin
        xa = pt[4] - (slp[2] * (pt[5] - r)) / 65536;
        xb = pt[4] - (slp[3] * (pt[5] - r)) / 65536;
      end
      if (bot_flat || r <= bot_end) walk = PH_IDLE;
      else row_now = r - 1;
    end
    lo = (xa < xb) ? xa : xb;
    hi = (xa > xb) ? xa : xb;
    s = (lo - 1 > 0) ? lo - 1 : 0;
    if (s > SCREEN_WIDTH - 1) s = SCREEN_WIDTH - 1;
    e = (hi + 1 < SCREEN_WIDTH - 1) ? hi + 1 : SCREEN_WIDTH - 1;
    if (e < 0) e = 0;
    sp.row = r[9:0]; sp.col_lo = s[9:0]; sp.col_hi = e[9:0];
    sp.color = flat_color; sp.last = (walk == PH_IDLE);
    spans_due.push_back(sp);
    if (walk == PH_IDLE) row_now = 0;
  endfunction

  function automatic void check_field(string name, longint exp_v, longint act_v);
    if (exp_v != act_v) begin
      $error("%s: expected %0d, got %0d", name, exp_v, act_v);
      errors++;
    end
  endfunction

  // monitor and predictor
  always @(posedge clk_i) begin
    span_t sp;
    item_t it;
    cycles++;
    if (cycles > 3000000) begin
      $display("end of test: mismatches");
      $finish;
    end else if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        out_acc = 1;
        n_spans++;
        if (spans_due.size() == 0) begin
          $error("span with no expected span waiting: %h", m_axis_tdata);
          errors++;
        end else begin
          sp = spans_due.pop_front();
          check_field("span_row", sp.row, m_axis_tdata[9:0]);
          check_field("span_start", sp.col_lo, m_axis_tdata[19:10]);
          check_field("span_end", sp.col_hi, m_axis_tdata[29:20]);
          check_field("span_color", sp.color, m_axis_tdata[53:30]);
          check_field("last_span", sp.last, m_axis_tlast);
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        in_acc = 1;
        it = {s_axis_tuser, s_axis_tdata[15:0], s_axis_tdata[31:16], s_axis_tdata[47:32],
              s_axis_tdata[63:48], s_axis_tdata[79:64], s_axis_tdata[95:80],
              s_axis_tdata[111:96], s_axis_tdata[127:112], s_axis_tdata[143:128],
              s_axis_tdata[167:144]};
        if (!it.is_tick) begin
          n_loads++;
          load_triangle(it);
        end else begin
          n_ticks++;
          if (walk != PH_IDLE) next_span();
        end
      end
      if (cfg_we_i) begin
        case (cfg_idx_e'(cfg_addr_i))
          CFG_LIGHT_X: light_x = cfg_wdata_i;
          CFG_LIGHT_Y: light_y = cfg_wdata_i;
          CFG_LIGHT_Z: light_z = cfg_wdata_i;
          default: ;
        endcase
      end
    end
  end

  // input driver
  always @(negedge clk_i) begin
    item_t it;
    if (in_acc) begin
      in_acc = 0;
      s_axis_tvalid = 1'b0;
      if ($urandom_range(0, 39) == 0) quiet = !quiet;
      send_gap = quiet ? 0 : $urandom_range(0, 18);
    end
    if (rst_ni && !s_axis_tvalid) begin
      if (send_gap > 0) send_gap--;
      else if (pending_items.size() > 0) begin
        it = pending_items.pop_front();
        s_axis_tuser = it.is_tick;
        s_axis_tdata = {it.base_color, it.normal_z, it.normal_y, it.normal_x, it.v2_y,
                        it.v2_x, it.v1_y, it.v1_x, it.v0_y, it.v0_x};
        s_axis_tvalid = 1'b1;
      end
    end
  end

  // output receiver
  always @(negedge clk_i) begin
    if (long_hold > 0) begin
      long_hold--;
      m_axis_tready = 1'b0;
    end else if (out_acc) begin
      out_acc = 0;
      recv_stall = quiet ? 0 : $urandom_range(0, 18);
      m_axis_tready = (recv_stall == 0);
    end else if (recv_stall > 0) begin
      recv_stall--;
      m_axis_tready = (recv_stall == 0);
    end else m_axis_tready = rst_ni;
  end

  function automatic item_t tick_item();
    item_t it;
    it = ITEM_W'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom});
    it.is_tick = 1'b1;
    return it;
  endfunction

  function automatic item_t tri_item(int spread);
    item_t it;
    int cx, cy;
    it = ITEM_W'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom});
    it.is_tick = 1'b0;
    if (spread > 0) begin
      cx = $urandom_range(0, 16383) - 8192;
      cy = $urandom_range(0, 16383) - 8192;
      it.v0_x = 16'(cx + $urandom_range(0, 2 * spread) - spread);
      it.v0_y = 16'(cy + $urandom_range(0, 2 * spread) - spread);
      it.v1_x = 16'(cx + $urandom_range(0, 2 * spread) - spread);
      it.v1_y = 16'(cy + $urandom_range(0, 2 * spread) - spread);
      it.v2_x = 16'(cx + $urandom_range(0, 2 * spread) - spread);
      it.v2_y = 16'(cy + $urandom_range(0, 2 * spread) - spread);
    end
    if ($urandom_range(0, 2) == 0) begin
      it.normal_x = 16'($urandom_range(0, 32767));
      it.normal_y = 16'($urandom_range(0, 32767));
      it.normal_z = 16'($urandom_range(0, 32767));
    end
    return it;
  endfunction

  function automatic item_t tri_at(int x0, int y0, int x1, int y1, int x2, int y2);
    item_t it;
    it = tri_item(0);
    it.v0_x = 16'(x0); it.v0_y = 16'(y0);
    it.v1_x = 16'(x1); it.v1_y = 16'(y1);
    it.v2_x = 16'(x2); it.v2_y = 16'(y2);
    return it;
  endfunction

  task automatic push_ticks(int n);
    repeat (n) pending_items.push_back(tick_item());
  endtask

  task automatic drain();
    while (pending_items.size() > 0 || s_axis_tvalid || spans_due.size() > 0)
      @(posedge clk_i);
    repeat (300) @(posedge clk_i);  // a load may still be in setup
  endtask

  task automatic write_light(cfg_idx_e idx, logic [15:0] val);
    @(negedge clk_i);
    cfg_we_i = 1'b1; cfg_addr_i = idx; cfg_wdata_i = val;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
  endtask

  initial begin
    item_t it;
    int sent;
    logic [15:0] lights [6][3] = '{
      '{16'h7fff, 16'h7fff, 16'h7fff}, '{16'h8000, 16'h8000, 16'h8000},
      '{16'h0000, 16'h0000, 16'h7fff}, '{16'h8000, 16'h7fff, 16'h0001},
      '{16'h0000, 16'h0000, 16'h0000}, '{16'h1234, 16'hedcb, 16'h5a5a}};

    repeat (10) @(negedge clk_i);
    rst_ni = 1'b1;

    // directed: idle tick, extremes, flat halves, off-screen and spanless triangles
    push_ticks(1);
    it = tri_at(-32768, -32768, 32767, 32767, -32768, 32767);
    it.normal_x = 16'h7fff; it.normal_y = 16'h7fff; it.normal_z = 16'h7fff;
    it.base_color = 24'hffffff;
    pending_items.push_back(it); push_ticks(3);
    it = tri_at(32767, 32767, -32768, -32768, 32767, -32768);
    it.normal_x = 16'h8000; it.normal_y = 16'h8000; it.normal_z = 16'h8000;
    it.base_color = 24'h000000;
    pending_items.push_back(it); push_ticks(2);
    pending_items.push_back(tri_at(-4000, 0, 3000, 0, 0, 900)); push_ticks(40);
    pending_items.push_back(tri_at(-4000, 0, 3000, 0, 500, 0)); push_ticks(3);
    pending_items.push_back(tri_at(-4000, -8192, 3000, -8192, 0, -8192)); push_ticks(2);
    pending_items.push_back(tri_at(0, -8700, -600, -7900, 700, -7800)); push_ticks(20);
    pending_items.push_back(tri_at(0, 8300, -600, 7900, 700, 8000)); push_ticks(20);
    pending_items.push_back(tri_at(-8192, -9000, 9000, 9000, 1000, 0)); push_ticks(3);
    pending_items.push_back(tri_at(100, 100, 900, 700, -500, 1200)); push_ticks(4);
    drain();

    for (int ph = 0; ph < 7; ph++) begin
      if (ph > 0) begin
        write_light(CFG_LIGHT_X, lights[ph-1][0]);
        write_light(CFG_LIGHT_Y, lights[ph-1][1]);
        write_light(CFG_LIGHT_Z, lights[ph-1][2]);
      end
      if (ph == 2) begin
        @(posedge clk_i);
        long_hold = 600;
      end
      sent = 0;
      while (sent < 60) begin
        case ($urandom_range(0, 9))
          0: pending_items.push_back(tri_item(0));
          1: pending_items.push_back(tri_item(6000));
          2: begin
            pending_items.push_back(tri_item(0));
            push_ticks(1);
            sent++;
          end
          default: pending_items.push_back(tri_item($urandom_range(1, 900)));
        endcase
        sent++;
        if ($urandom_range(0, 9) != 0) begin
          int k;
          k = $urandom_range(1, 45);
          push_ticks(k);
          sent += k;
        end
      end
      drain();
    end

    $display("loads %0d, ticks %0d, spans checked %0d over seven light settings",
             n_loads, n_ticks, n_spans);
    if (errors == 0) $display("end of test: clean");
    else $display("end of test: mismatches");
    $finish;
  end

endmodule

@@ sim.f @@
design/fstsr_pkg.sv
design/fstsr_front.sv
design/fstsr_div.sv
design/fstsr_back.sv
design/flat_shaded_triangle_span_rasterizer.sv
design/fstsr_checker.sv
dv/flat_shaded_triangle_span_rasterizer_test.sv
